// ===== hdl/ecpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Enhanced clock page replacement package
// Sizes, field widths and fault kind codes shared by the replacement unit.
// ----------------------------------------------------------------------------
package ecpr_pkg;

    localparam int FRAMES      = 4;
    localparam int PAGES       = 8;
    localparam int OFFSET_BITS = 10;

    localparam int FRAME_W = $clog2(FRAMES);
    localparam int PAGE_W  = $clog2(PAGES);
    localparam int FILL_W  = $clog2(FRAMES + 1);

    localparam int ADDR_W  = 13;
    localparam int PADDR_W = 12;
    localparam int KIND_W  = 2;
    localparam int EVICT_W = 3;
    localparam int FNUM_W  = 2;

    localparam int IN_TDATA_W  = ((ADDR_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = FNUM_W + PADDR_W + EVICT_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_HIT     = 2'd0;
    localparam t_kind KIND_FILL    = 2'd1;
    localparam t_kind KIND_REPLACE = 2'd2;

endpackage

// ===== hdl/enhanced_clock_page_replacement.sv =====
// ----------------------------------------------------------------------------
// Enhanced clock page replacement unit
// Translates logical accesses through a page table and replaces pages by the
// enhanced clock scheme when no physical frame is free.
// ----------------------------------------------------------------------------
// One item is taken at a time. A hit or a load into a free frame goes through
// the lookup and done states before the next item can be accepted; a replacement
// also runs the victim search, one pass per cycle through a single rotated
// priority selector over all frames, starting at the hand, and at most four
// passes are needed. Results sit in an output register, so the next item is
// accepted while a result still waits to be taken.
module enhanced_clock_page_replacement
    import ecpr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Bits from low: logical_address[12:0], zero fill.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Bits from low: is_write.
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Bits from low: frame_number[1:0], physical_address[11:0],
    // evicted_page[2:0], zero fill.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // Bits from low: fault_kind[1:0].
    output logic [KIND_W-1:0]      m_axis_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [1:0] PASS_CLEAR = 2'd1;
    localparam logic [1:0] PASS_LAST  = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [1:0]             r_pass;
    logic [1:0]             n_pass;
    logic [PAGE_W-1:0]      r_page;
    logic [OFFSET_BITS-1:0] r_offset;
    logic                   r_wr;

    logic [PAGES-1:0]       r_present;
    logic [FRAME_W-1:0]     r_page_frame [PAGES];
    logic [PAGE_W-1:0]      r_owner      [FRAMES];
    logic [FRAMES-1:0]      r_ref;
    logic [FRAMES-1:0]      r_dirty;
    logic [FILL_W-1:0]      r_filled;
    logic [FRAME_W-1:0]     r_hand;

    logic [FRAME_W-1:0]     r_res_frame;
    t_kind                  r_res_kind;
    logic [PAGE_W-1:0]      r_res_evict;

    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;
    t_kind                  r_m_tuser;

    logic                   in_accept;
    logic                   out_free;

    logic                   s_found;
    logic [FRAME_W-1:0]     s_victim;
    logic [FRAME_W-1:0]     s_idx;
    logic [FRAMES-1:0]      s_clear;

    logic                   hit_en;
    logic                   inst_en;
    logic [FRAME_W-1:0]     inst_frame;
    t_kind                  inst_kind;
    logic [PAGE_W-1:0]      inst_evict;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // Rotated priority select: the first frame from the hand that matches the
    // pass, and the frames passed over before it.
    always_comb begin
        s_found  = 1'b0;
        s_victim = r_hand;
        s_clear  = '0;
        s_idx    = r_hand;
        for (int k = 0; k < FRAMES; k++) begin
            s_idx = r_hand + FRAME_W'(k);
            if (!s_found) begin
                if (!r_ref[s_idx] && (r_dirty[s_idx] == r_pass[0])) begin
                    s_found  = 1'b1;
                    s_victim = s_idx;
                end else begin
                    s_clear[s_idx] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pass     = r_pass;
        hit_en     = 1'b0;
        inst_en    = 1'b0;
        inst_frame = r_filled[FRAME_W-1:0];
        inst_kind  = KIND_FILL;
        inst_evict = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (r_present[r_page]) begin
                    hit_en  = 1'b1;
                    n_state = ST_DONE;
                end else if (r_filled < FILL_W'(FRAMES)) begin
                    inst_en = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_pass  = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (s_found || (r_pass == PASS_LAST)) begin
                    inst_en    = 1'b1;
                    inst_frame = s_found ? s_victim : r_hand;
                    inst_kind  = KIND_REPLACE;
                    inst_evict = r_owner[inst_frame];
                    n_state    = ST_DONE;
                end else begin
                    n_pass = r_pass + 2'd1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pass    <= '0;
            r_present <= '0;
            r_ref     <= '0;
            r_dirty   <= '0;
            r_filled  <= '0;
            r_hand    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;

            if (in_accept) begin
                r_page   <= s_axis_tdata[OFFSET_BITS +: PAGE_W];
                r_offset <= s_axis_tdata[OFFSET_BITS-1:0];
                r_wr     <= s_axis_tuser;
            end

            if (hit_en) begin
                r_ref[r_page_frame[r_page]] <= 1'b1;
                if (r_wr) begin
                    r_dirty[r_page_frame[r_page]] <= 1'b1;
                end
                r_res_frame <= r_page_frame[r_page];
                r_res_kind  <= KIND_HIT;
                r_res_evict <= '0;
            end

            if ((r_state == ST_SCAN) && (r_pass == PASS_CLEAR)) begin
                for (int f = 0; f < FRAMES; f++) begin
                    if (s_clear[f]) begin
                        r_ref[f] <= 1'b0;
                    end
                end
            end

            if (inst_en) begin
                if (inst_kind == KIND_REPLACE) begin
                    r_present[inst_evict] <= 1'b0;
                    r_hand                <= inst_frame + FRAME_W'(1);
                end else begin
                    r_filled <= r_filled + FILL_W'(1);
                end
                r_owner[inst_frame]  <= r_page;
                r_ref[inst_frame]    <= 1'b1;
                r_dirty[inst_frame]  <= r_wr;
                r_present[r_page]    <= 1'b1;
                r_page_frame[r_page] <= inst_frame;
                r_res_frame          <= inst_frame;
                r_res_kind           <= inst_kind;
                r_res_evict          <= inst_evict;
            end

            if ((r_state == ST_DONE) && out_free) begin
                r_m_valid <= 1'b1;
                r_m_tdata <= OUT_TDATA_W'({r_res_evict, r_res_frame, r_offset,
                                           r_res_frame});
                r_m_tuser <= r_res_kind;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= FILL_W'(FRAMES))
        else $error("Frame fill count exceeds the number of frames.");

    a_present_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_present) == int'(r_filled))
        else $error("Resident page count disagrees with the fill count.");

    a_replace_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_tuser == KIND_REPLACE)) |-> (r_filled == FILL_W'(FRAMES)))
        else $error("A page was replaced while a frame was still free.");

    a_hand_moves_on_replace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SCAN) |=> $stable(r_hand))
        else $error("The clock hand moved outside a victim search.");

endmodule
